@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame checker and converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define HTFC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// A condition at one edge that must be followed by another at the next edge.
`define HTFC_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/htfc_pkg.sv @@
// ----------------------------------------------------------------------------
// htfc_pkg
// Types, constants and the CRC-8 step shared by the frame checker modules.
// ----------------------------------------------------------------------------
package htfc_pkg;

  // CRC-8, polynomial 0x31, initial value 0xFF, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within the six-byte frame.
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Frame status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_T_CRC = 2'd1;
  localparam logic [1:0] ST_H_CRC = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // Conversion constants.
  localparam logic [14:0] T_SCALE      = 15'd17500;
  localparam logic [14:0] T_OFFSET     = 15'd4450;  // 4500 less the rounding term 50
  localparam logic [6:0]  H_SCALE      = 7'd100;
  localparam logic [6:0]  H_MAX        = 7'd100;
  localparam logic [13:0] DIV100_RECIP = 14'd10486; // ceil(2^20 / 100)
  localparam int          DIV100_SHIFT = 20;

  // One checked frame on its way from the front to the back.
  typedef struct packed {
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    logic [1:0]  status;
  } htfc_rec_t;

  // Queue read side as seen by the back.
  typedef struct packed {
    logic      empty;
    htfc_rec_t rec;
  } htfc_qout_t;

  // Feed one byte into the running CRC.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/htfc_front.sv @@
// ----------------------------------------------------------------------------
// htfc_front
// Assembles the six-byte frame, runs the CRC checks and emits one record.
// ----------------------------------------------------------------------------
module htfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          frame_byte,
  input  logic                frame_start,
  output logic                rec_wr,
  output htfc_pkg::htfc_rec_t rec
);
  import htfc_pkg::*;

  logic [2:0]  pos_r, pos_nxt, pos;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] t_raw_r, t_raw_nxt;
  logic [7:0]  h_hi_r, h_hi_nxt;
  logic [7:0]  h_lo_r, h_lo_nxt;
  logic        t_ok_r, t_ok_nxt;

  // Effective position: a start flag forces the first byte of a frame.
  always_comb begin
    pos = frame_start ? POS_T_HI : pos_r;
    if (pos > POS_H_CRC) begin
      pos = POS_T_HI;
    end
  end

  // Per-byte update of the frame state.
  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    t_raw_nxt = t_raw_r;
    h_hi_nxt  = h_hi_r;
    h_lo_nxt  = h_lo_r;
    t_ok_nxt  = t_ok_r;
    if (accept) begin
      case (pos)
        POS_T_HI: begin
          crc_nxt   = crc8_feed(CRC_INIT, frame_byte);
          t_raw_nxt = {frame_byte, 8'd0};
        end
        POS_T_LO: begin
          crc_nxt   = crc8_feed(crc_r, frame_byte);
          t_raw_nxt = {t_raw_r[15:8], frame_byte};
        end
        POS_T_CRC: begin
          t_ok_nxt = (crc_r == frame_byte);
        end
        POS_H_HI: begin
          crc_nxt  = crc8_feed(CRC_INIT, frame_byte);
          h_hi_nxt = frame_byte;
        end
        POS_H_LO: begin
          crc_nxt  = crc8_feed(crc_r, frame_byte);
          h_lo_nxt = frame_byte;
        end
        default: begin
        end
      endcase
      pos_nxt = (pos == POS_H_CRC) ? POS_T_HI : pos + 3'd1;
    end
  end

  // The sixth byte closes the frame and produces a record.
  always_comb begin
    rec_wr     = accept && (pos == POS_H_CRC);
    rec.t_raw  = t_raw_r;
    rec.h_raw  = {h_hi_r, h_lo_r};
    if (!t_ok_r) begin
      rec.status = ST_T_CRC;
    end else if (crc_r != frame_byte) begin
      rec.status = ST_H_CRC;
    end else begin
      rec.status = ST_OK;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_T_HI;
      crc_r  <= CRC_INIT;
      t_ok_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      t_ok_r <= t_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_raw_r <= t_raw_nxt;
    h_hi_r  <= h_hi_nxt;
    h_lo_r  <= h_lo_nxt;
  end

endmodule

@@ rtl/htfc_queue.sv @@
// ----------------------------------------------------------------------------
// htfc_queue
// Short record queue that decouples the frame front from the conversion back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  htfc_pkg::htfc_rec_t  wr_rec,
  output logic                 full,
  input  logic                 rd_en,
  output htfc_pkg::htfc_qout_t rd
);
  import htfc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  htfc_rec_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd.empty = (count_r == '0);
  assign rd.rec   = mem[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && !rd.empty;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Checks on the fill count.
  `HTFC_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `HTFC_ASSERT_NEXT(a_count_up, clk, rst_n, do_wr && !do_rd, count_r == $past(count_r) + 1'b1, "queue count did not rise on a write")

endmodule

@@ rtl/htfc_back.sv @@
// ----------------------------------------------------------------------------
// htfc_back
// Five-stage conversion pipeline from raw words to degrees and percent.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htfc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  htfc_pkg::htfc_qout_t q,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic signed [8:0]    out_temperature_c,
  output logic [6:0]           out_humidity_pct,
  output logic [1:0]           out_frame_status
);
  import htfc_pkg::*;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic        rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [30:0] s1_pt_r, s1_pt_nxt;
  logic [22:0] s1_ph_r, s1_ph_nxt;
  logic [1:0]  s1_st_r;

  logic [31:0] t_sum;
  logic [23:0] h_sum;
  logic [14:0] s2_tq_r, s2_tq_nxt;
  logic [6:0]  s2_h_r, s2_h_nxt, hq;
  logic [1:0]  s2_st_r;

  logic [13:0] s3_m_r, s3_m_nxt;
  logic        s3_neg_r, s3_neg_nxt;
  logic [6:0]  s3_h_r;
  logic [1:0]  s3_st_r;

  logic [27:0] s4_pm_r, s4_pm_nxt;
  logic        s4_neg_r;
  logic [6:0]  s4_h_r;
  logic [1:0]  s4_st_r;

  logic [7:0]  mag;
  logic [8:0]  s5_t_r, s5_t_nxt;
  logic [6:0]  s5_h_r;
  logic [1:0]  s5_st_r;

  // Stall chain: a stage moves when it is empty or the next one moves.
  assign rdy5  = !v5_r || out_pop;
  assign rdy4  = !v4_r || rdy5;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign q_pop = !q.empty && rdy1;

  // Stage 1: scale both raw words.
  always_comb begin
    s1_pt_nxt = 31'(q.rec.t_raw) * 31'(T_SCALE);
    s1_ph_nxt = 23'(q.rec.h_raw) * 23'(H_SCALE);
  end

  // Stage 2: floor division by 65535 as (x + 1 + (x >> 16)) >> 16, humidity clamp.
  always_comb begin
    t_sum     = 32'(s1_pt_r) + 32'd1 + 32'(s1_pt_r[30:16]);
    h_sum     = 24'(s1_ph_r) + 24'd1 + 24'(s1_ph_r[22:16]);
    s2_tq_nxt = t_sum[30:16];
    hq        = h_sum[22:16];
    s2_h_nxt  = (hq > H_MAX) ? H_MAX : hq;
  end

  // Stage 3: apply the offset and split into sign and magnitude.
  always_comb begin
    if (s2_tq_r < T_OFFSET) begin
      s3_neg_nxt = 1'b1;
      s3_m_nxt   = 14'(T_OFFSET - s2_tq_r);
    end else begin
      s3_neg_nxt = 1'b0;
      s3_m_nxt   = 14'(s2_tq_r - T_OFFSET);
    end
  end

  // Stage 4: magnitude divided by 100 through a reciprocal multiply.
  assign s4_pm_nxt = 28'(s3_m_r) * 28'(DIV100_RECIP);

  // Stage 5: restore the sign, which gives truncation toward zero.
  always_comb begin
    mag      = s4_pm_r[27:DIV100_SHIFT];
    s5_t_nxt = s4_neg_r ? (9'd0 - {1'b0, mag}) : {1'b0, mag};
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= q_pop;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_pt_r <= s1_pt_nxt;
      s1_ph_r <= s1_ph_nxt;
      s1_st_r <= q.rec.status;
    end
    if (rdy2) begin
      s2_tq_r <= s2_tq_nxt;
      s2_h_r  <= s2_h_nxt;
      s2_st_r <= s1_st_r;
    end
    if (rdy3) begin
      s3_m_r   <= s3_m_nxt;
      s3_neg_r <= s3_neg_nxt;
      s3_h_r   <= s2_h_r;
      s3_st_r  <= s2_st_r;
    end
    if (rdy4) begin
      s4_pm_r  <= s4_pm_nxt;
      s4_neg_r <= s3_neg_r;
      s4_h_r   <= s3_h_r;
      s4_st_r  <= s3_st_r;
    end
    if (rdy5) begin
      s5_t_r  <= s5_t_nxt;
      s5_h_r  <= s4_h_r;
      s5_st_r <= s4_st_r;
    end
  end

  assign out_empty         = !v5_r;
  assign out_temperature_c = $signed(s5_t_r);
  assign out_humidity_pct  = s5_h_r;
  assign out_frame_status  = s5_st_r;

  // Checks on delivered results.
  `HTFC_ASSERT(a_status_code, clk, rst_n, out_empty || (out_frame_status != ST_BAD), "result status code out of range")
  `HTFC_ASSERT(a_hum_range, clk, rst_n, out_empty || (out_humidity_pct <= H_MAX), "humidity above clamp")
  `HTFC_ASSERT(a_temp_range, clk, rst_n, out_empty || ((out_temperature_c >= -9'sd44) && (out_temperature_c <= 9'sd130)), "temperature out of range")

endmodule

@@ rtl/humidity_temp_frame_check_convert.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert
// Checks six-byte temperature and humidity frames with CRC-8 and converts them.
// ----------------------------------------------------------------------------
// Channel  Ports                                         Moves
// input    in_push, in_full, in_frame_byte, in_frame_start  one frame byte per item
// result   out_empty, out_pop, out_temperature_c,          one result per frame
//          out_humidity_pct, out_frame_status
//
// One byte is accepted per cycle while in_full is low.
// The edge that accepts a frame's sixth byte writes its record into the queue;
// from there the record moves into the first of the five conversion stages and
// on to the last, which drives the result ports; a stalled stage ahead holds it.
// Reset is synchronous on rst_n; it clears the byte position and all valid state.
// in_full rises only when the record queue holds QUEUE_DEPTH frames that the
// stalled result side has not yet drained; while it is high every byte waits,
// including bytes that do not close a frame.
// ----------------------------------------------------------------------------
module humidity_temp_frame_check_convert #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_frame_byte,
  input  logic              in_frame_start,
  output logic              out_empty,
  input  logic              out_pop,
  output logic signed [8:0] out_temperature_c,
  output logic [6:0]        out_humidity_pct,
  output logic [1:0]        out_frame_status
);
  import htfc_pkg::*;

  logic       accept;
  logic       rec_wr;
  htfc_rec_t  rec;
  htfc_qout_t q;
  logic       q_pop;
  logic       q_full;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Frame assembly and CRC check.
  htfc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_byte  (in_frame_byte),
    .frame_start (in_frame_start),
    .rec_wr      (rec_wr),
    .rec         (rec)
  );

  // Record queue between front and back.
  htfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_wr),
    .wr_rec (rec),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd     (q)
  );

  // Conversion pipeline and result register.
  htfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q                 (q),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_temperature_c (out_temperature_c),
    .out_humidity_pct  (out_humidity_pct),
    .out_frame_status  (out_frame_status)
  );

endmodule
